/* rtl/core/dds_pkg.sv */
// Shared constants and types for the distributed delay step core.
package dds_pkg;

    localparam int MAX_STAGES   = 64;
    localparam int STAGE_AW     = $clog2(MAX_STAGES);
    localparam int STAGE_CW     = $clog2(MAX_STAGES + 1);
    localparam int MAX_SUBSTEPS = 16;
    localparam int SUBSTEP_W    = 5;
    localparam int SUBIDX_W     = $clog2(MAX_SUBSTEPS);
    localparam int REM_W        = $clog2(MAX_SUBSTEPS);

    localparam int AMT_W      = 32;
    localparam int COEF_W     = 17;
    localparam int TOT_W      = 48;
    localparam int STEP_W     = AMT_W + 1;
    localparam int PROD_W     = AMT_W + COEF_W;
    localparam int DRAIN_W    = AMT_W + SUBIDX_W;
    localparam int CONTENTS_W = AMT_W + STAGE_AW;
    localparam int CLASS_W    = AMT_W + 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [COEF_W-1:0] Q_ONE = COEF_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STAGE_COUNT      = 3'd0,
        CFG_FLOW_COEFFICIENT = 3'd1,
        CFG_RETENTION_FACTOR = 3'd2,
        CFG_SUBSTEP_COUNT    = 3'd3,
        CFG_INITIAL_INFLOW   = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* rtl/core/dds_ram.sv */
// Generic single write port RAM with one registered read port.
module dds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/dds_mul.sv */
// Shared Q1.16 coefficient by Q16.16 amount multiplier, registered scaled product.
module dds_mul (
    input  logic                       clk,
    input  logic [dds_pkg::COEF_W-1:0] coef,
    input  logic [dds_pkg::AMT_W-1:0]  operand,
    output logic [dds_pkg::AMT_W-1:0]  scaled
);

    logic [dds_pkg::PROD_W-1:0] product;

    assign product = dds_pkg::PROD_W'(coef) * dds_pkg::PROD_W'(operand);

    // coef never exceeds one, so the scaled product never exceeds the operand
    always_ff @(posedge clk)
    begin
        scaled <= product[dds_pkg::AMT_W+15:16];
    end

endmodule

/* rtl/core/dds_div.sv */
// Bit-serial restoring divider splitting the step inflow over the substeps.
module dds_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dds_pkg::STEP_W-1:0]    dividend,
    input  logic [dds_pkg::SUBSTEP_W-1:0] divisor,
    output logic [dds_pkg::STEP_W-1:0]    quotient,
    output logic [dds_pkg::REM_W-1:0]     remainder,
    output dds_pkg::div_status_t          status
);

    localparam int CNT_W = $clog2(dds_pkg::STEP_W + 1);

    logic [dds_pkg::STEP_W-1:0]    q_reg;
    logic [dds_pkg::REM_W-1:0]     r_reg;
    logic [dds_pkg::SUBSTEP_W-1:0] d_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [dds_pkg::REM_W:0]       trial;
    logic                          fits;

    assign trial = {r_reg, q_reg[dds_pkg::STEP_W-1]};
    assign fits  = ({1'b0, trial} >= {1'b0, d_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[dds_pkg::STEP_W-2:0], fits};
            r_reg <= fits ? dds_pkg::REM_W'(trial - d_reg) : dds_pkg::REM_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(dds_pkg::STEP_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = q_reg;
    assign remainder   = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/core/distributed_delay_step_core.sv */
// Top level: sequencer walking the age classes through the shared multiplier.
//
// Distributed delay with attrition, one time step per input word.
// Slave stream: s_tdata carries the step inflow (Q16.16). Master stream:
// m_tdata carries outflow, contents, inflow total and outflow total.
// Configuration words are to be written through cfg_we / cfg_index / cfg_data
// only while the core is idle; the core itself does not enforce this.
// Unknown indexes are ignored. Each word is split over the substeps by a
// serial divider, then every substep walks the classes from the last to the
// first through one shared 17x32 multiplier, three products per class.
// Age classes sit in a 64-entry RAM with one valid flop per entry, so
// reset clears them at once and no clearing pass is run.
// The result waits in an output register; the next word is accepted
// while it waits, but that word's result is held back until the receiver
// takes the earlier one.
// Reset restores the register defaults, clears the classes and totals and
// arms the one-off initial inflow.
module distributed_delay_step_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] inflow
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] outflow, [63:32] contents, [111:64] inflow_total,
    // [159:112] outflow_total
    output logic [159:0]                     m_tdata,
    input  logic                             cfg_we,
    input  logic [dds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dds_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        IDLE,
        DIV,
        SUB_START,
        RD_LAST,
        DRAIN,
        LOSS1,
        LOSS2,
        MOVE
    } state_t;

    localparam int AW = dds_pkg::STAGE_AW;
    localparam int AMT_W = dds_pkg::AMT_W;

    // configuration
    logic [6:0]                    stage_count_reg;
    logic [dds_pkg::COEF_W-1:0]    flow_coefficient_reg;
    logic [dds_pkg::COEF_W-1:0]    retention_factor_reg;
    logic [dds_pkg::SUBSTEP_W-1:0] substep_count_reg;
    logic [AMT_W-1:0]              initial_inflow_reg;

    state_t                           state_reg;
    logic                             first_pending_reg;
    logic [dds_pkg::TOT_W-1:0]        inflow_sum_reg;
    logic [dds_pkg::TOT_W-1:0]        outflow_sum_reg;
    logic [dds_pkg::STAGE_CW-1:0]     k_reg;
    logic [dds_pkg::SUBSTEP_W-1:0]    n_reg;
    logic [dds_pkg::COEF_W-1:0]       a_reg;
    logic [dds_pkg::COEF_W-1:0]       b_reg;
    logic [AW-1:0]                    i_reg;
    logic [dds_pkg::SUBIDX_W-1:0]     j_reg;
    logic [dds_pkg::STEP_W-1:0]       share_reg;
    logic [dds_pkg::STEP_W-1:0]       enter_reg;
    logic [AMT_W-1:0]                 x_cur_reg;
    logic [AMT_W-1:0]                 x_prev_reg;
    logic [AMT_W-1:0]                 leave_reg;
    logic [dds_pkg::DRAIN_W-1:0]      drained_reg;
    logic [dds_pkg::CONTENTS_W-1:0]   total_reg;
    logic [dds_pkg::MAX_STAGES-1:0]   valid_reg;
    logic                             rd_valid_reg;
    logic                             m_tvalid_reg;
    logic [AMT_W-1:0]                 out_outflow_reg;
    logic [AMT_W-1:0]                 out_contents_reg;
    logic [dds_pkg::TOT_W-1:0]        out_inflow_total_reg;
    logic [dds_pkg::TOT_W-1:0]        out_outflow_total_reg;

    logic                             s_accept;
    logic [dds_pkg::STEP_W-1:0]       step_in;
    logic [dds_pkg::TOT_W:0]          inflow_sum_wide;
    logic [dds_pkg::STAGE_CW-1:0]     k_clamp;
    logic [dds_pkg::SUBSTEP_W-1:0]    n_clamp;
    logic [dds_pkg::COEF_W-1:0]       a_clamp;
    logic [dds_pkg::COEF_W-1:0]       b_clamp;
    logic [dds_pkg::STEP_W-1:0]       div_quotient;
    logic [dds_pkg::REM_W-1:0]        div_remainder;
    dds_pkg::div_status_t             div_status;

    logic [AW-1:0]                    last_idx;
    logic [AW-1:0]                    ram_raddr;
    logic [AW-1:0]                    ram_waddr;
    logic                             ram_we;
    logic [AMT_W-1:0]                 ram_rdata;
    logic [AMT_W-1:0]                 rd_val;
    logic                             rd_issue;

    logic [dds_pkg::COEF_W-1:0]       mul_coef;
    logic [AMT_W-1:0]                 mul_operand;
    logic [AMT_W-1:0]                 mul_q;

    logic [dds_pkg::CLASS_W-1:0]      class_sum;
    logic [AMT_W-1:0]                 class_val;
    logic                             last_substep;
    logic                             out_load;
    logic [AMT_W-1:0]                 drained_sat;
    logic [AMT_W-1:0]                 contents_sat;
    logic [dds_pkg::TOT_W:0]          outflow_sum_wide;
    logic [dds_pkg::TOT_W-1:0]        outflow_sum_sat;

    // ---------------------------------------------------------------- input side
    assign s_tready = (state_reg == IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign step_in  = dds_pkg::STEP_W'(s_tdata)
                    + (first_pending_reg ? dds_pkg::STEP_W'(initial_inflow_reg) : '0);
    assign inflow_sum_wide = {1'b0, inflow_sum_reg} + (dds_pkg::TOT_W + 1)'(step_in);

    always_comb
    begin
        if (stage_count_reg == '0)
            k_clamp = dds_pkg::STAGE_CW'(1);
        else if (stage_count_reg > dds_pkg::MAX_STAGES)
            k_clamp = dds_pkg::STAGE_CW'(dds_pkg::MAX_STAGES);
        else
            k_clamp = dds_pkg::STAGE_CW'(stage_count_reg);

        if (substep_count_reg == '0)
            n_clamp = dds_pkg::SUBSTEP_W'(1);
        else if (substep_count_reg > dds_pkg::MAX_SUBSTEPS)
            n_clamp = dds_pkg::SUBSTEP_W'(dds_pkg::MAX_SUBSTEPS);
        else
            n_clamp = substep_count_reg;

        a_clamp = (flow_coefficient_reg > dds_pkg::Q_ONE) ? dds_pkg::Q_ONE
                                                          : flow_coefficient_reg;
        b_clamp = (retention_factor_reg > dds_pkg::Q_ONE) ? dds_pkg::Q_ONE
                                                          : retention_factor_reg;
    end

    dds_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_accept),
        .dividend  (step_in),
        .divisor   (n_clamp),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    // ---------------------------------------------------------------- class store
    assign last_idx = AW'(k_reg - 1'b1);

    always_comb
    begin
        ram_raddr = last_idx;
        rd_issue  = 1'b0;
        case (state_reg)
            SUB_START:
            begin
                ram_raddr = last_idx;
                rd_issue  = 1'b1;
            end
            DRAIN:
            begin
                ram_raddr = i_reg - 1'b1;
                rd_issue  = (i_reg != '0);
            end
            MOVE:
            begin
                ram_raddr = i_reg - AW'(2);
                rd_issue  = (i_reg > AW'(1));
            end
            default:
            begin
                ram_raddr = last_idx;
                rd_issue  = 1'b0;
            end
        endcase
    end

    // class zero is written in LOSS2; MOVE with index zero is only the wrap-up wait
    assign ram_we    = (state_reg == MOVE && i_reg != '0) || (state_reg == LOSS2 && i_reg == '0);
    assign ram_waddr = i_reg;

    dds_ram #(
        .WIDTH (AMT_W),
        .DEPTH (dds_pkg::MAX_STAGES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (class_val),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // a class never written reads as zero
    assign rd_val = rd_valid_reg ? ram_rdata : '0;

    // ---------------------------------------------------------------- shared multiplier
    always_comb
    begin
        case (state_reg)
            RD_LAST:
            begin
                mul_coef    = a_reg;
                mul_operand = rd_val;
            end
            DRAIN:
            begin
                mul_coef    = b_reg;
                mul_operand = x_cur_reg;
            end
            LOSS1:
            begin
                mul_coef    = a_reg;
                mul_operand = mul_q;
            end
            LOSS2:
            begin
                mul_coef    = a_reg;
                mul_operand = x_prev_reg;
            end
            MOVE:
            begin
                mul_coef    = b_reg;
                mul_operand = x_prev_reg;
            end
            default:
            begin
                mul_coef    = a_reg;
                mul_operand = x_cur_reg;
            end
        endcase
    end

    dds_mul u_mul (
        .clk     (clk),
        .coef    (mul_coef),
        .operand (mul_operand),
        .scaled  (mul_q)
    );

    // new class value: own + incoming - leaving; leaving never exceeds own
    always_comb
    begin
        if (state_reg == MOVE)
            class_sum = dds_pkg::CLASS_W'(x_cur_reg) + dds_pkg::CLASS_W'(mul_q)
                      - dds_pkg::CLASS_W'(leave_reg);
        else
            class_sum = dds_pkg::CLASS_W'(x_cur_reg) + dds_pkg::CLASS_W'(enter_reg)
                      - dds_pkg::CLASS_W'(mul_q);
        class_val = (|class_sum[dds_pkg::CLASS_W-1:AMT_W]) ? '1 : class_sum[AMT_W-1:0];
    end

    assign last_substep = ({1'b0, j_reg} + 1'b1) == n_reg;

    // ---------------------------------------------------------------- result
    assign out_load     = !m_tvalid_reg || m_tready;
    assign drained_sat  = (|drained_reg[dds_pkg::DRAIN_W-1:AMT_W]) ? '1
                                                                 : drained_reg[AMT_W-1:0];
    assign contents_sat = (|total_reg[dds_pkg::CONTENTS_W-1:AMT_W]) ? '1
                                                                  : total_reg[AMT_W-1:0];
    assign outflow_sum_wide = {1'b0, outflow_sum_reg} + (dds_pkg::TOT_W + 1)'(drained_sat);
    assign outflow_sum_sat  = outflow_sum_wide[dds_pkg::TOT_W] ? '1
                                                               : outflow_sum_wide[dds_pkg::TOT_W-1:0];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_outflow_total_reg, out_inflow_total_reg,
                       out_contents_reg, out_outflow_reg};

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            k_reg <= k_clamp;
            n_reg <= n_clamp;
            a_reg <= a_clamp;
            b_reg <= b_clamp;
        end
        if (state_reg == DIV && div_status.done)
        begin
            share_reg <= div_quotient;
            enter_reg <= div_quotient + dds_pkg::STEP_W'(div_remainder);
        end
        else if (state_reg == LOSS2 && i_reg == '0)
        begin
            enter_reg <= share_reg;
        end
        if (state_reg == RD_LAST)
            x_cur_reg <= rd_val;
        else if (state_reg == MOVE)
            x_cur_reg <= x_prev_reg;
        if (state_reg == LOSS1)
            x_prev_reg <= rd_val;
        if (state_reg == LOSS2)
            leave_reg <= mul_q;
        if (state_reg == DIV && div_status.done)
            drained_reg <= '0;
        else if (state_reg == DRAIN && i_reg == last_idx)
            drained_reg <= drained_reg + dds_pkg::DRAIN_W'(mul_q);
        if (state_reg == DIV && div_status.done)
            total_reg <= '0;
        else if (ram_we && last_substep)
            total_reg <= total_reg + dds_pkg::CONTENTS_W'(class_val);
        rd_valid_reg <= valid_reg[ram_raddr];
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg       <= 7'd30;
            flow_coefficient_reg  <= dds_pkg::COEF_W'(7282);
            retention_factor_reg  <= dds_pkg::Q_ONE;
            substep_count_reg     <= dds_pkg::SUBSTEP_W'(1);
            initial_inflow_reg    <= '0;
            state_reg             <= IDLE;
            first_pending_reg     <= 1'b1;
            inflow_sum_reg        <= '0;
            outflow_sum_reg       <= '0;
            valid_reg             <= '0;
            i_reg                 <= '0;
            j_reg                 <= '0;
            m_tvalid_reg          <= 1'b0;
            out_outflow_reg       <= '0;
            out_contents_reg      <= '0;
            out_inflow_total_reg  <= '0;
            out_outflow_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (dds_pkg::cfg_index_t'(cfg_index))
                    dds_pkg::CFG_STAGE_COUNT:      stage_count_reg      <= cfg_data[6:0];
                    dds_pkg::CFG_FLOW_COEFFICIENT:
                        flow_coefficient_reg <= cfg_data[dds_pkg::COEF_W-1:0];
                    dds_pkg::CFG_RETENTION_FACTOR:
                        retention_factor_reg <= cfg_data[dds_pkg::COEF_W-1:0];
                    dds_pkg::CFG_SUBSTEP_COUNT:
                        substep_count_reg    <= cfg_data[dds_pkg::SUBSTEP_W-1:0];
                    dds_pkg::CFG_INITIAL_INFLOW:   initial_inflow_reg   <= cfg_data;
                    default:                       ;
                endcase
            end

            if (state_reg == MOVE && i_reg == '0 && out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (ram_we)
                valid_reg[ram_waddr] <= 1'b1;

            case (state_reg)
                IDLE:
                begin
                    if (s_accept)
                    begin
                        first_pending_reg <= 1'b0;
                        inflow_sum_reg    <= inflow_sum_wide[dds_pkg::TOT_W] ? '1
                                           : inflow_sum_wide[dds_pkg::TOT_W-1:0];
                        state_reg         <= DIV;
                    end
                end
                DIV:
                begin
                    if (div_status.done)
                    begin
                        j_reg     <= '0;
                        state_reg <= SUB_START;
                    end
                end
                SUB_START:
                begin
                    i_reg     <= last_idx;
                    state_reg <= RD_LAST;
                end
                RD_LAST:
                begin
                    state_reg <= DRAIN;
                end
                DRAIN:
                begin
                    state_reg <= LOSS1;
                end
                LOSS1:
                begin
                    state_reg <= LOSS2;
                end
                LOSS2:
                begin
                    if (i_reg != '0)
                    begin
                        state_reg <= MOVE;
                    end
                    else if (!last_substep)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= SUB_START;
                    end
                    else
                    begin
                        // wrap-up: hand over the result once the output is free
                        state_reg <= MOVE;
                    end
                end
                MOVE:
                begin
                    if (i_reg != '0)
                    begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= LOSS1;
                    end
                    else if (out_load)
                    begin
                        outflow_sum_reg       <= outflow_sum_sat;
                        out_outflow_reg       <= drained_sat;
                        out_contents_reg      <= contents_sat;
                        out_inflow_total_reg  <= inflow_sum_reg;
                        out_outflow_total_reg <= outflow_sum_sat;
                        state_reg             <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    // attrition can never take more than the class holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LOSS2) |-> (mul_q <= x_cur_reg))
        else $error("class loss exceeds class contents");

    // the class walk stays inside the classes in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LOSS1 || state_reg == LOSS2) |-> (i_reg <= last_idx))
        else $error("class index beyond stage count");

    // a read never targets the class being written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && rd_issue) |-> (ram_waddr != ram_raddr))
        else $error("read and write collide on one class");

    // the outflow total never decreases
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> (outflow_sum_reg >= $past(outflow_sum_reg)))
        else $error("outflow total went down");

endmodule

/* tb/sv/distributed_delay_step_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the distributed delay step core: stream stimulus and a scoreboard.
module distributed_delay_step_core_tb;

    localparam int          CLK_HALF        = 5;
    localparam int          CYCLE_LIMIT     = 20_000_000;
    localparam int          STEP_CYCLES_MAX = 3200;
    localparam int          RANDOM_PHASES   = 18;
    localparam logic [63:0] MASK32          = 64'hFFFF_FFFF;
    localparam logic [63:0] MASK48          = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] UNITY           = 64'd65536;

    typedef struct {
        logic [dds_pkg::AMT_W-1:0] outflow;
        logic [dds_pkg::AMT_W-1:0] contents;
        logic [dds_pkg::TOT_W-1:0] inflow_total;
        logic [dds_pkg::TOT_W-1:0] outflow_total;
    } step_result_t;

    class delay_step_board;
        logic [6:0]                stages;
        logic [16:0]               flow;
        logic [16:0]               retention;
        logic [4:0]                substeps;
        logic [dds_pkg::AMT_W-1:0] initial_amount;
        logic [dds_pkg::AMT_W-1:0] chain [dds_pkg::MAX_STAGES];
        logic [63:0]               inflow_sum;
        logic [63:0]               outflow_sum;
        bit                        first_pending;
        step_result_t              expected_steps [$];
        int                        errors;
        int                        checked;

        function new();
            stages         = 7'd30;
            flow           = 17'd7282;
            retention      = 17'd65536;
            substeps       = 5'd1;
            initial_amount = '0;
            foreach (chain[i]) chain[i] = '0;
            inflow_sum     = '0;
            outflow_sum    = '0;
            first_pending  = 1'b1;
            errors         = 0;
            checked        = 0;
        endfunction

        function void set_register(logic [dds_pkg::CFG_IDX_W-1:0] idx,
                                   logic [dds_pkg::CFG_DATA_W-1:0] value);
            case (dds_pkg::cfg_index_t'(idx))
                dds_pkg::CFG_STAGE_COUNT:      stages         = value[6:0];
                dds_pkg::CFG_FLOW_COEFFICIENT: flow           = value[16:0];
                dds_pkg::CFG_RETENTION_FACTOR: retention      = value[16:0];
                dds_pkg::CFG_SUBSTEP_COUNT:    substeps       = value[4:0];
                dds_pkg::CFG_INITIAL_INFLOW:   initial_amount = value;
                default: ;
            endcase
        endfunction

        function logic [63:0] capped_sum(logic [63:0] x, logic [63:0] y, logic [63:0] lim);
            logic [63:0] s;
            s = x + y;
            return (s > lim) ? lim : s;
        endfunction

        function logic [63:0] attrition(logic [63:0] x, logic [63:0] a, logic [63:0] b);
            return (a * ((b * x) >> 16)) >> 16;
        endfunction

        function step_result_t advance_chain(logic [dds_pkg::AMT_W-1:0] inflow);
            step_result_t r;
            int           k;
            int           n;
            logic [63:0]  a, b, step_in, share, rest, drained, total, enter, x, v;
            k = int'(stages);
            n = int'(substeps);
            if (k < 1) k = 1;
            if (k > dds_pkg::MAX_STAGES) k = dds_pkg::MAX_STAGES;
            if (n < 1) n = 1;
            if (n > dds_pkg::MAX_SUBSTEPS) n = dds_pkg::MAX_SUBSTEPS;
            a = 64'(flow);
            b = 64'(retention);
            if (a > UNITY) a = UNITY;
            if (b > UNITY) b = UNITY;
            step_in = 64'(inflow);
            if (first_pending)
            begin
                step_in       = step_in + 64'(initial_amount);
                first_pending = 1'b0;
            end
            inflow_sum = capped_sum(inflow_sum, step_in, MASK48);
            share      = step_in / 64'(n);
            rest       = step_in - share * 64'(n);
            drained    = '0;
            for (int j = 0; j < n; j++)
            begin
                // remainder of the split goes in with the first substep
                enter   = share + ((j == 0) ? rest : 64'd0);
                drained = drained + ((a * 64'(chain[k-1])) >> 16);
                for (int i = k - 1; i > 0; i--)
                begin
                    x        = 64'(chain[i]);
                    v        = x + ((a * 64'(chain[i-1])) >> 16) - attrition(x, a, b);
                    chain[i] = (v > MASK32) ? MASK32[31:0] : v[31:0];
                end
                x        = 64'(chain[0]);
                v        = x + enter - attrition(x, a, b);
                chain[0] = (v > MASK32) ? MASK32[31:0] : v[31:0];
            end
            if (drained > MASK32) drained = MASK32;
            outflow_sum = capped_sum(outflow_sum, drained, MASK48);
            total = '0;
            for (int i = 0; i < k; i++) total = total + 64'(chain[i]);
            if (total > MASK32) total = MASK32;
            r.outflow       = drained[31:0];
            r.contents      = total[31:0];
            r.inflow_total  = inflow_sum[47:0];
            r.outflow_total = outflow_sum[47:0];
            return r;
        endfunction

        function void note_inflow(logic [dds_pkg::AMT_W-1:0] inflow);
            expected_steps.push_back(advance_chain(inflow));
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_word(logic [159:0] word);
            step_result_t e;
            if (expected_steps.size() == 0)
            begin
                report("unexpected result word, outflow", 64'(word[31:0]), '0);
                return;
            end
            e = expected_steps.pop_front();
            checked++;
            if (word[31:0] !== e.outflow)
                report("outflow", 64'(word[31:0]), 64'(e.outflow));
            if (word[63:32] !== e.contents)
                report("contents", 64'(word[63:32]), 64'(e.contents));
            if (word[111:64] !== e.inflow_total)
                report("inflow_total", 64'(word[111:64]), 64'(e.inflow_total));
            if (word[159:112] !== e.outflow_total)
                report("outflow_total", 64'(word[159:112]), 64'(e.outflow_total));
        endtask
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [31:0]                    s_tdata;    // [31:0] inflow
    logic                           m_tvalid;
    logic                           m_tready;
    logic [159:0]                   m_tdata;    // [31:0] outflow, [63:32] contents,
                                                // [111:64] inflow_total, [159:112] outflow_total
    logic                           cfg_we;
    logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dds_pkg::CFG_DATA_W-1:0] cfg_data;

    delay_step_board board = new();
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int words_sent         = 0;
    int settings_used      = 0;
    int cycles             = 0;

    distributed_delay_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("distributed_delay_step_core_tb NOT OK");
        $finish;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_word(m_tdata);

    task automatic write_reg(input logic [dds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dds_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic apply_setting(input logic [31:0] k, input logic [31:0] a,
                                 input logic [31:0] b, input logic [31:0] n,
                                 input logic [31:0] init);
        write_reg(dds_pkg::CFG_STAGE_COUNT, k);
        write_reg(dds_pkg::CFG_FLOW_COEFFICIENT, a);
        write_reg(dds_pkg::CFG_RETENTION_FACTOR, b);
        write_reg(dds_pkg::CFG_SUBSTEP_COUNT, n);
        write_reg(dds_pkg::CFG_INITIAL_INFLOW, init);
        settings_used++;
    endtask

    task automatic send_step(input logic [dds_pkg::AMT_W-1:0] inflow);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= inflow;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_inflow(inflow);
        words_sent++;
    endtask

    task automatic sender_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        sender_idle();
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] random_inflow();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2, 3:    return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_coefficient();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 32'd65536;
            2:       return $urandom_range(65537, 131071);
            3:       return 32'd1;
            default: return $urandom_range(1, 65536);
        endcase
    endfunction

    // junk above the register width must be dropped by the core
    function automatic logic [31:0] with_spare_bits(input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask = (32'd1 << width) - 32'd1;
        return (value & mask) | ($urandom & ~mask);
    endfunction

    initial
    begin
        int k, n, keff, neff, items;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults, with the one-off inflow stacked on a full first word
        write_reg(dds_pkg::CFG_INITIAL_INFLOW, 32'hFFFF_FFFF);
        send_step(32'hFFFF_FFFF);
        send_step(32'h0);
        send_step(32'h1);
        send_step(32'h0001_0000);
        drain_results();

        for (int s = int'(dds_pkg::CFG_INITIAL_INFLOW) + 1; s < 2**dds_pkg::CFG_IDX_W; s++)
            write_reg(dds_pkg::CFG_IDX_W'(s), $urandom);

        // single class, full flow, no attrition: class saturates
        apply_setting(1, 65536, 0, 1, 0);
        repeat (3) send_step(32'hFFFF_FFFF);
        drain_results();

        // zero counts and coefficients above one
        apply_setting(0, 131071, 131071, 0, 32'h5A5A_5A5A);
        send_step(32'hFFFF_FFFF);
        send_step(32'h1234_5678);
        drain_results();

        // oversized counts clamp; chain fills and outflow saturates
        apply_setting(127, 65536, 0, 31, 0);
        repeat (5) send_step(32'hFFFF_FFFF);
        drain_results();

        // no flow, upper classes left untouched, uneven split
        apply_setting(8, 0, 40000, 3, 0);
        send_step(32'd7);
        send_step(32'hFFFF_FFFE);
        send_step(32'd5);
        drain_results();

        apply_setting(64, 65536, 65536, 16, 0);
        send_step(32'hFFFF_FFFF);
        send_step(32'd15);
        drain_results();

        apply_setting(2, 1, 1, 16, 0);
        send_step(32'hFFFF_FFFF);
        send_step(32'd17);
        send_step(32'd0);
        drain_results();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 48;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 48;
                end
                default:
                begin
                    sender_idle_pct    = 17;
                    receiver_stall_pct = 17;
                end
            endcase
            if ($urandom_range(99) < 85)
            begin
                k = $urandom_range(1, 12);
                n = $urandom_range(1, 4);
            end
            else
            begin
                k = $urandom_range(0, 127);
                n = $urandom_range(0, 31);
            end
            apply_setting(with_spare_bits(k, 7), with_spare_bits(random_coefficient(), 17),
                          with_spare_bits(random_coefficient(), 17), with_spare_bits(n, 5),
                          $urandom);
            keff  = (k < 1) ? 1 : (k > dds_pkg::MAX_STAGES) ? dds_pkg::MAX_STAGES : k;
            neff  = (n < 1) ? 1 : (n > dds_pkg::MAX_SUBSTEPS) ? dds_pkg::MAX_SUBSTEPS : n;
            items = (keff * neff > 96) ? 8 : 72;
            for (int i = 0; i < items; i++)
            begin
                // hold the sender back until the core has emptied
                if (phase % 4 == 1 && i == items / 2)
                begin
                    sender_idle();
                    while (board.pending() != 0) @(posedge clk);
                end
                send_step(random_inflow());
            end
            drain_results();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (STEP_CYCLES_MAX) @(posedge clk);
        if (board.pending() != 0)
            board.report("results still owed", 64'(board.pending()), '0);
        $display("%0d steps sent over %0d register settings, %0d result words compared",
                 words_sent, settings_used, board.checked);
        $display("idle mixes: none, sender, receiver, both; chains of 1 to 64 classes");
        if (board.errors == 0)
            $display("distributed_delay_step_core_tb OK");
        else
            $display("distributed_delay_step_core_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/dds_pkg.sv
rtl/core/dds_ram.sv
rtl/core/dds_mul.sv
rtl/core/dds_div.sv
rtl/core/distributed_delay_step_core.sv
tb/sv/distributed_delay_step_core_tb.sv
